// File: hdl/bdq_pkg.sv
// shared types and constants for the bounded deque with eviction
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [OPCODE_W-1:0] OP_ADD_FRONT  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_BACK   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_TAKE_FRONT = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TAKE_BACK  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_PEEK_BACK  = 3'd5;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  entry_value;
   } req_word_type;

   typedef struct packed {
      logic                status;
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_word_type;

   // source of a result loaded into the output or pending register
   typedef enum logic [1:0] {
      SEL_DIRECT = 2'd0,
      SEL_READ   = 2'd1,
      SEL_PEND   = 2'd2
   } res_sel_type;

   typedef struct packed {
      logic        exec;
      logic        out_load;
      logic        pend_load;
      res_sel_type sel;
   } bdq_cmd_type;

   typedef struct packed {
      logic peek_hit;
      logic out_free;
   } bdq_sts_type;

endpackage

// File: hdl/bdq_ctrl.sv
// controller state machine for the bounded deque
`timescale 1ns / 1ps

module bdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bdq_pkg::bdq_sts_type sts,
   output bdq_pkg::bdq_cmd_type cmd
);
   import bdq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.exec      = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.pend_load = 1'b0;
      cmd.sel       = SEL_DIRECT;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               if (sts.peek_hit) begin
                  state_in = ST_READ;
               end else if (sts.out_free) begin
                  cmd.out_load = 1'b1;
               end else begin
                  cmd.pend_load = 1'b1;
                  state_in      = ST_WAIT;
               end
            end
         end
         ST_READ: begin
            cmd.sel = SEL_READ;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.pend_load = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            cmd.sel = SEL_PEND;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/bdq_datapath.sv
// ring storage, pointers, capacity register and result registers of the deque
`timescale 1ns / 1ps

module bdq_datapath #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bdq_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bdq_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_wr_en,
   input  logic [bdq_pkg::CAP_W-1:0]      csr_wr_data,
   input  bdq_pkg::bdq_cmd_type           cmd,
   output bdq_pkg::bdq_sts_type           sts
);
   import bdq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [PTR_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   rsp_word_type          pend_ff;
   rsp_word_type          rsp_ff;
   logic                  rsp_valid_ff;

   logic [PTR_W-1:0]      front_inc, front_dec, tail_idx, back_idx, wr_addr, rd_addr;
   logic [SUM_W-1:0]      tail_sum, back_sum;
   logic [CNT_W-1:0]      count_m1;
   logic [CMP_W-1:0]      eff_cap;
   logic                  empty, full, is_peek, status_direct, wr_en;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH+VALUE_W-1:0] wr_wide, rd_wide;
   logic [CNT_W+COUNT_W-1:0]      cnt_next_wide, cnt_cur_wide;
   rsp_word_type          res_direct, res_read, res_mux;

   // ring arithmetic, sums stay below twice the depth while the deque is not empty
   assign front_inc = (front_ff == PTR_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? PTR_W'(DEPTH - 1) : front_ff - 1'b1;
   assign count_m1  = count_ff - 1'b1;
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_sum  = SUM_W'(front_ff) + SUM_W'(count_m1);
   assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(tail_sum);
   assign back_idx  = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(back_sum);

   // zero capacity acts as one, capacity above depth acts as depth
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign empty   = (count_ff == '0);
   assign full    = (CMP_W'(count_ff) >= eff_cap);
   assign is_peek = (req_word.opcode == OP_PEEK_FRONT) || (req_word.opcode == OP_PEEK_BACK);
   assign rd_addr = (req_word.opcode == OP_PEEK_FRONT) ? front_ff : back_idx;

   assign sts.peek_hit = is_peek && !empty;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_idx;
      status_direct = STATUS_OK;
      unique case (req_word.opcode) inside
         OP_ADD_FRONT: begin
            front_in = front_dec;
            wr_en    = 1'b1;
            wr_addr  = front_dec;
            count_in = full ? count_ff : count_ff + 1'b1;
         end
         OP_ADD_BACK: begin
            // evicting the front leaves the tail slot where it was
            if (full) begin
               front_in = front_inc;
            end
            wr_en    = 1'b1;
            wr_addr  = tail_idx;
            count_in = full ? count_ff : count_ff + 1'b1;
         end
         OP_TAKE_FRONT: begin
            if (empty) begin
               status_direct = STATUS_EMPTY;
            end else begin
               front_in = front_inc;
               count_in = count_m1;
            end
         end
         OP_TAKE_BACK: begin
            if (empty) begin
               status_direct = STATUS_EMPTY;
            end else begin
               count_in = count_m1;
            end
         end
         OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (empty) begin
               status_direct = STATUS_EMPTY;
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_wide       = {{DATA_WIDTH{1'b0}}, req_word.entry_value};
   assign wr_data       = wr_wide[DATA_WIDTH-1:0];
   assign rd_wide       = {{VALUE_W{1'b0}}, rd_data_ff};
   assign cnt_next_wide = {{COUNT_W{1'b0}}, count_in};
   assign cnt_cur_wide  = {{COUNT_W{1'b0}}, count_ff};

   always_comb begin
      res_direct.status      = status_direct;
      res_direct.read_value  = '0;
      res_direct.entry_count = cnt_next_wide[COUNT_W-1:0];
      res_read.status        = STATUS_OK;
      res_read.read_value    = rd_wide[VALUE_W-1:0];
      res_read.entry_count   = cnt_cur_wide[COUNT_W-1:0];
      case (cmd.sel)
         SEL_DIRECT: res_mux = res_direct;
         SEL_READ:   res_mux = res_read;
         SEL_PEND:   res_mux = pend_ff;
         default:    res_mux = res_direct;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.exec && sts.peek_hit) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_ff <= res_mux;
      end
      if (cmd.out_load) begin
         rsp_ff <= res_mux;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// File: hdl/bounded_deque_with_eviction.sv
// top level of the bounded deque with eviction
`timescale 1ns / 1ps

// Double-ended queue of up to DEPTH entries kept in a ring memory. Each request
// word carries one operation (push front/back, pop front/back, peek front/back)
// and yields exactly one response word with status, peeked value and the count
// after the operation. A push onto a full queue (count at or above the
// csr-written capacity, clamped to 1..DEPTH) evicts the entry at the other end
// and succeeds; a pop or peek on an empty queue fails and changes nothing.
// Pushes, pops and no-op codes are answered from the request itself; a peek that
// finds an entry first passes through a read state, because the ring memory has
// a registered read port. An output register and a one-word pending register
// let the next request be taken while a response is still waiting. No clearing
// pass after reset; capacity may be written only while the block is idle.
module bounded_deque_with_eviction #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bdq_pkg::req_word_type     req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bdq_pkg::rsp_word_type     rsp_word,
   input  logic                      csr_wr_en,
   input  logic [bdq_pkg::CAP_W-1:0] csr_wr_data
);
   import bdq_pkg::*;

   bdq_cmd_type cmd;
   bdq_sts_type sts;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
